/* hdl/mlfs_pkg.sv */
package mlfs_pkg;

    typedef enum logic [2:0] {
        OP_WRITE_BYTE      = 3'd0,
        OP_WRITE_PIXEL     = 3'd1,
        OP_FILL            = 3'd2,
        OP_CLEAR_SCREEN    = 3'd3,
        OP_SEND_LINE       = 3'd4,
        OP_NEXT_FRAME_LINE = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIXEL,
        ST_FILL,
        ST_CLEAR,
        ST_CLEAR_TRAILER,
        ST_HEAD,
        ST_ROW,
        ST_DATA,
        ST_TRAILER,
        ST_TRAILER2
    } t_state;

    localparam logic [1:0] CFG_WRITE_COMMAND = 2'd0;
    localparam logic [1:0] CFG_CLEAR_COMMAND = 2'd1;
    localparam logic [1:0] CFG_TRAILER       = 2'd2;

    localparam logic [7:0] WRITE_COMMAND_RESET = 8'd128;
    localparam logic [7:0] CLEAR_COMMAND_RESET = 8'd32;
    localparam logic [7:0] TRAILER_RESET       = 8'd0;
    localparam logic [7:0] CLEAR_FILL_BYTE     = 8'hFF;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] write_command;
        logic [7:0] clear_command;
        logic [7:0] trailer;
    } t_cfg;

    typedef struct packed {
        t_op        op;
        logic [7:0] row_idx;
        logic [4:0] col_idx;
        logic [2:0] bit_idx;
        logic       pixel;
        logic [7:0] value;
    } t_job;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

/* hdl/memory_lcd_frame_serializer_unit.sv */
// Memory LCD frame serializer.
// Command channel: an item is taken at a rising edge with start high and busy
// low. Items pass through a two-entry queue to a sequencer that owns the frame
// store. Write byte writes the store on dispatch; write pixel reads the byte
// then, and ST_PIXEL writes it back. Fill and clear screen sweep the store at
// one byte per cycle over all LINES * LINE_BYTES bytes, clear screen after its
// command and trailer bytes. Send line emits LINE_BYTES + 4 bytes and a frame
// line LINE_BYTES + 2 to LINE_BYTES + 4, one byte per cycle, the data bytes
// read from the store port. The first result byte passes the queue, the idle
// dispatch and the output register before o_serial_byte. Each byte is shown
// for one cycle with o_strobe high, and o_last_of_run marks the final byte of
// an item. The receiver cannot stall. Configuration writes use i_cfg_valid,
// i_cfg_index and i_cfg_data; ready is always high. Write them only while the
// block is idle. Reset restores the register defaults and the frame position
// to line 1; the frame store holds no defined contents until written.
module memory_lcd_frame_serializer_unit
    import mlfs_pkg::*;
#(
    parameter int unsigned LINES      = 128,
    parameter int unsigned LINE_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_row_number,
    input  logic [4:0] i_column_number,
    input  logic [2:0] i_bit_index,
    input  logic       i_pixel_value,
    input  logic [7:0] i_byte_value,
    output logic       o_strobe,
    output logic [7:0] o_serial_byte,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg r_cfg;
    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_command <= WRITE_COMMAND_RESET;
            r_cfg.clear_command <= CLEAR_COMMAND_RESET;
            r_cfg.trailer       <= TRAILER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WRITE_COMMAND: r_cfg.write_command <= i_cfg_data;
                CFG_CLEAR_COMMAND: r_cfg.clear_command <= i_cfg_data;
                CFG_TRAILER:       r_cfg.trailer       <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    mlfs_front #(
        .LINES      (LINES),
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .start           (start),
        .i_full          (q_full),
        .i_cmd           (i_cmd),
        .i_row_number    (i_row_number),
        .i_column_number (i_column_number),
        .i_bit_index     (i_bit_index),
        .i_pixel_value   (i_pixel_value),
        .i_byte_value    (i_byte_value),
        .busy            (busy),
        .o_push          (push),
        .o_job           (push_job)
    );

    mlfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mlfs_back #(
        .LINES      (LINES),
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (q_empty),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_serial_byte (o_serial_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* hdl/mlfs_front.sv */
module mlfs_front
    import mlfs_pkg::*;
#(
    parameter int unsigned LINES      = 128,
    parameter int unsigned LINE_BYTES = 16
) (
    input  logic       start,
    input  logic       i_full,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_row_number,
    input  logic [4:0] i_column_number,
    input  logic [2:0] i_bit_index,
    input  logic       i_pixel_value,
    input  logic [7:0] i_byte_value,
    output logic       busy,
    output logic       o_push,
    output t_job       o_job
);

    logic row_ok;
    logic col_ok;
    logic keep;

    assign busy   = i_full;
    assign row_ok = (i_row_number >= 8'd1) && (32'(i_row_number) <= LINES);
    assign col_ok = (i_column_number >= 5'd1) && (32'(i_column_number) <= LINE_BYTES);

    always_comb begin
        keep          = 1'b0;
        o_job.op      = t_op'(i_cmd);
        o_job.row_idx = i_row_number - 8'd1;
        o_job.col_idx = i_column_number - 5'd1;
        o_job.bit_idx = i_bit_index;
        o_job.pixel   = i_pixel_value;
        o_job.value   = i_byte_value;
        case (i_cmd)
            OP_WRITE_BYTE:      keep = row_ok && col_ok;
            OP_WRITE_PIXEL:     keep = row_ok && col_ok;
            OP_FILL:            keep = 1'b1;
            OP_CLEAR_SCREEN:    keep = 1'b1;
            OP_SEND_LINE:       keep = row_ok;
            OP_NEXT_FRAME_LINE: keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    assign o_push = start && !i_full && keep;

endmodule

/* hdl/mlfs_queue.sv */
module mlfs_queue
    import mlfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_entry [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_job   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* hdl/mlfs_back.sv */
module mlfs_back
    import mlfs_pkg::*;
#(
    parameter int unsigned LINES      = 128,
    parameter int unsigned LINE_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_strobe,
    output logic [7:0] o_serial_byte,
    output logic       o_last_of_run
);

    localparam int unsigned DEPTH = LINES * LINE_BYTES;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr,  n_addr;
    logic [AW-1:0] r_base,  n_base;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [7:0]    r_row,   n_row;
    logic [7:0]    r_fill,  n_fill;
    logic [2:0]    r_bit,   n_bit;
    logic          r_pix,   n_pix;
    logic          r_tail2, n_tail2;
    logic [7:0]    r_nfl,   n_nfl;
    logic          r_strobe, n_strobe;
    logic [7:0]    r_byte,  n_byte;
    logic          r_last,  n_last;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    logic [7:0]    line;
    logic [7:0]    row_sel;
    logic [AW-1:0] base_calc;
    logic [7:0]    mask;

    assign o_strobe      = r_strobe;
    assign o_serial_byte = r_byte;
    assign o_last_of_run = r_last;

    assign line      = (r_nfl >= 8'd1 && 32'(r_nfl) <= LINES) ? r_nfl : 8'd1;
    assign row_sel   = (i_job.op == OP_NEXT_FRAME_LINE) ? line - 8'd1 : i_job.row_idx;
    assign base_calc = AW'(32'(row_sel) * LINE_BYTES);
    assign mask      = 8'd1 << r_bit;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_nfl    <= 8'd1;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nfl    <= n_nfl;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
        r_addr  <= n_addr;
        r_base  <= n_base;
        r_cnt   <= n_cnt;
        r_row   <= n_row;
        r_fill  <= n_fill;
        r_bit   <= n_bit;
        r_pix   <= n_pix;
        r_tail2 <= n_tail2;
        r_byte  <= n_byte;
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_base   = r_base;
        n_cnt    = r_cnt;
        n_row    = r_row;
        n_fill   = r_fill;
        n_bit    = r_bit;
        n_pix    = r_pix;
        n_tail2  = r_tail2;
        n_nfl    = r_nfl;
        n_strobe = 1'b0;
        n_byte   = r_byte;
        n_last   = 1'b0;
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_addr;
        wr_en    = 1'b0;
        wr_addr  = r_addr;
        wr_data  = r_fill;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_job.op)
                        OP_WRITE_BYTE: begin
                            wr_en   = 1'b1;
                            wr_addr = base_calc + AW'(i_job.col_idx);
                            wr_data = i_job.value;
                        end
                        OP_WRITE_PIXEL: begin
                            rd_en   = 1'b1;
                            rd_addr = base_calc + AW'(i_job.col_idx);
                            n_addr  = base_calc + AW'(i_job.col_idx);
                            n_bit   = i_job.bit_idx;
                            n_pix   = i_job.pixel;
                            n_state = ST_PIXEL;
                        end
                        OP_FILL: begin
                            n_fill  = i_job.value;
                            n_addr  = '0;
                            n_state = ST_FILL;
                        end
                        OP_CLEAR_SCREEN: begin
                            n_fill  = CLEAR_FILL_BYTE;
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        OP_SEND_LINE: begin
                            n_row   = i_job.row_idx + 8'd1;
                            n_base  = base_calc;
                            n_tail2 = 1'b1;
                            n_state = ST_HEAD;
                        end
                        OP_NEXT_FRAME_LINE: begin
                            n_row   = line;
                            n_base  = base_calc;
                            n_tail2 = (32'(line) == LINES);
                            n_nfl   = (32'(line) == LINES) ? 8'd1 : line + 8'd1;
                            n_state = (line == 8'd1) ? ST_HEAD : ST_ROW;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PIXEL: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = r_pix ? (r_rdata | mask) : (r_rdata & ~mask);
                n_state = ST_IDLE;
            end
            ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = r_fill;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_CLEAR: begin
                n_strobe = 1'b1;
                n_byte   = i_cfg.clear_command;
                n_state  = ST_CLEAR_TRAILER;
            end
            ST_CLEAR_TRAILER: begin
                n_strobe = 1'b1;
                n_byte   = i_cfg.trailer;
                n_last   = 1'b1;
                n_state  = ST_FILL;
            end
            ST_HEAD: begin
                n_strobe = 1'b1;
                n_byte   = i_cfg.write_command;
                n_state  = ST_ROW;
            end
            ST_ROW: begin
                n_strobe = 1'b1;
                n_byte   = flip8(r_row);
                rd_en    = 1'b1;
                rd_addr  = r_base;
                n_addr   = r_base + 1'b1;
                n_cnt    = '0;
                n_state  = ST_DATA;
            end
            ST_DATA: begin
                n_strobe = 1'b1;
                n_byte   = r_rdata;
                if (r_cnt == CW'(LINE_BYTES - 1)) begin
                    n_state = ST_TRAILER;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr;
                    n_addr  = r_addr + 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            ST_TRAILER: begin
                n_strobe = 1'b1;
                n_byte   = i_cfg.trailer;
                n_last   = !r_tail2;
                n_state  = r_tail2 ? ST_TRAILER2 : ST_IDLE;
            end
            ST_TRAILER2: begin
                n_strobe = 1'b1;
                n_byte   = i_cfg.trailer;
                n_last   = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_last) |=> r_strobe)
        else $error("byte run interrupted before its last item");

    a_run_end_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |-> (r_state == ST_IDLE || r_state == ST_FILL))
        else $error("run ended while sequencer still emitting");

    a_frame_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfl >= 8'd1) && (32'(r_nfl) <= LINES))
        else $error("frame line position out of range");

endmodule
